// File: design/pfb_pkg.sv
package pfb_pkg;

  // Fixed field widths of the item and result ports.
  localparam int unsigned COMMAND_W = 2;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned BYTE_W    = 8;
  // Internal page and column numbers, wide enough for the largest screen.
  localparam int unsigned PAGE_W    = 4;
  localparam int unsigned COL_W     = 8;

  localparam logic [COMMAND_W-1:0] CMD_BLIT  = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_PIXEL = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_READ  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SET,
    OP_CLEAR,
    OP_XOR
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_UP,
    ST_WRITE_UP,
    ST_READ_LO,
    ST_WRITE_LO
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the decoded item
    logic clear;   // write zero at the sweep address and advance it
    logic read;    // read the selected frame byte
    logic write;   // modify, write back and report the selected byte
    logic sel_lo;  // select the lower (spilled) part
    logic last;    // this report is the last of the item
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_done;
    logic has_up;    // incoming item has an upper part
    logic has_lo;    // incoming item has a lower part
    logic has_lo_q;  // captured item has a lower part
  } ctrl_stat_t;

  function automatic logic [BYTE_W-1:0] apply_op(input logic [BYTE_W-1:0] old,
                                                 input logic [BYTE_W-1:0] mask,
                                                 input op_t op);
    logic [BYTE_W-1:0] res;
    case (op)
      OP_SET:   res = old | mask;
      OP_CLEAR: res = old & ~mask;
      OP_XOR:   res = old ^ mask;
      default:  res = old;
    endcase
    return res;
  endfunction

endpackage

// File: design/pfb_ctrl.sv
module pfb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pfb_pkg::ctrl_stat_t stat,
  output pfb_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  pfb_pkg::state_t state;
  pfb_pkg::state_t state_next;
  logic            accept;

  assign busy   = (state != pfb_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pfb_pkg::ST_CLEAR: begin
        if (stat.clear_done) begin
          state_next = pfb_pkg::ST_IDLE;
        end
      end
      pfb_pkg::ST_IDLE: begin
        if (accept) begin
          if (stat.has_up) begin
            state_next = pfb_pkg::ST_READ_UP;
          end else if (stat.has_lo) begin
            state_next = pfb_pkg::ST_READ_LO;
          end
        end
      end
      pfb_pkg::ST_READ_UP:  state_next = pfb_pkg::ST_WRITE_UP;
      pfb_pkg::ST_WRITE_UP: begin
        state_next = stat.has_lo_q ? pfb_pkg::ST_READ_LO : pfb_pkg::ST_IDLE;
      end
      pfb_pkg::ST_READ_LO:  state_next = pfb_pkg::ST_WRITE_LO;
      pfb_pkg::ST_WRITE_LO: state_next = pfb_pkg::ST_IDLE;
      default:              state_next = pfb_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      pfb_pkg::ST_CLEAR:    cmd.clear = !stat.clear_done;
      pfb_pkg::ST_IDLE:     cmd.load = accept;
      pfb_pkg::ST_READ_UP:  cmd.read = 1'b1;
      pfb_pkg::ST_WRITE_UP: begin
        cmd.write = 1'b1;
        cmd.last  = !stat.has_lo_q;
      end
      pfb_pkg::ST_READ_LO: begin
        cmd.read   = 1'b1;
        cmd.sel_lo = 1'b1;
      end
      pfb_pkg::ST_WRITE_LO: begin
        cmd.write  = 1'b1;
        cmd.sel_lo = 1'b1;
        cmd.last   = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/pfb_datapath.sv
module pfb_datapath #(
  parameter int unsigned SCREEN_COLUMNS = 128,
  parameter int unsigned SCREEN_PAGES   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  pfb_pkg::ctrl_cmd_t  cmd,
  output pfb_pkg::ctrl_stat_t stat,
  input  logic [1:0]          command,
  input  logic signed [7:0]   origin_x,
  input  logic signed [7:0]   origin_y,
  input  logic [7:0]          col_offset,
  input  logic [4:0]          band,
  input  logic [7:0]          bitmap_byte,
  input  logic [1:0]          mode,
  input  logic [7:0]          blit_width,
  input  logic [7:0]          blit_height,
  output logic                strobe,
  output logic [2:0]          page_index,
  output logic [6:0]          column_index,
  output logic [7:0]          byte_value,
  output logic                is_last
);

  localparam int unsigned PGW   = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  localparam int unsigned CW    = $clog2(SCREEN_COLUMNS);
  localparam int unsigned AW    = PGW + CW;
  localparam int unsigned DEPTH = 2 ** AW;

  // Decode of the incoming item.
  logic signed [9:0]            col_s;
  logic signed [6:0]            top;
  logic signed [6:0]            top_p1;
  logic [15:0]                  shifted;
  logic                         geom_ok;
  logic                         col_on;
  logic                         up_on;
  logic                         lo_on;
  logic                         px_on;
  logic                         py_on;
  logic                         d_has_up;
  logic                         d_has_lo;
  logic [pfb_pkg::PAGE_W-1:0]   d_page_up;
  logic [pfb_pkg::PAGE_W-1:0]   d_page_lo;
  logic [pfb_pkg::COL_W-1:0]    d_col;
  logic [7:0]                   d_mask_up;
  logic [7:0]                   d_mask_lo;
  pfb_pkg::op_t                 d_op;

  // Captured item.
  logic [pfb_pkg::PAGE_W-1:0]   page_up;
  logic [pfb_pkg::PAGE_W-1:0]   page_lo;
  logic [pfb_pkg::COL_W-1:0]    col;
  logic [7:0]                   mask_up;
  logic [7:0]                   mask_lo;
  pfb_pkg::op_t                 op;
  logic                         has_lo_q;

  logic [7:0]                   frame_mem [DEPTH];
  logic [7:0]                   rdata;
  logic [AW:0]                  clr_cnt;
  logic [pfb_pkg::PAGE_W-1:0]   sel_page;
  logic [AW-1:0]                addr;
  logic [7:0]                   new_byte;

  assign col_s   = {{2{origin_x[7]}}, origin_x} + {2'b00, col_offset};
  assign top     = {{2{origin_y[7]}}, origin_y[7:3]} + {2'b00, band};
  assign top_p1  = top + 7'sd1;
  assign shifted = {8'h00, bitmap_byte} << origin_y[2:0];
  assign geom_ok = (col_offset < blit_width) &&
                   ({1'b0, band, 3'b000} < {1'b0, blit_height});
  assign col_on  = !col_s[9] && (col_s[8:0] < 9'(SCREEN_COLUMNS));
  assign up_on   = !top[6] && (top[5:0] < 6'(SCREEN_PAGES));
  assign lo_on   = (origin_y[2:0] != 3'd0) && !top_p1[6] &&
                   (top_p1[5:0] < 6'(SCREEN_PAGES));
  assign px_on   = !origin_x[7] && ({1'b0, origin_x} < 9'(SCREEN_COLUMNS));
  assign py_on   = !origin_y[7] && ({1'b0, origin_y} < 9'(SCREEN_PAGES * 8));

  always_comb begin
    d_has_up  = 1'b0;
    d_has_lo  = 1'b0;
    d_page_up = top[pfb_pkg::PAGE_W-1:0];
    d_page_lo = top_p1[pfb_pkg::PAGE_W-1:0];
    d_col     = col_s[pfb_pkg::COL_W-1:0];
    d_mask_up = shifted[7:0];
    d_mask_lo = shifted[15:8];
    d_op      = pfb_pkg::OP_NONE;
    case (command)
      pfb_pkg::CMD_BLIT: begin
        d_has_up = geom_ok && col_on && up_on;
        d_has_lo = geom_ok && col_on && lo_on;
        if (mode == pfb_pkg::MODE_SET) begin
          d_op = pfb_pkg::OP_SET;
        end else if (mode == pfb_pkg::MODE_CLEAR) begin
          d_op = pfb_pkg::OP_CLEAR;
        end else begin
          d_op = pfb_pkg::OP_XOR;
        end
      end
      pfb_pkg::CMD_PIXEL, pfb_pkg::CMD_READ: begin
        d_has_up  = px_on && py_on;
        d_page_up = origin_y[6:3];
        d_col     = origin_x;
        d_mask_up = 8'h01 << origin_y[2:0];
        if (command == pfb_pkg::CMD_READ) begin
          d_op = pfb_pkg::OP_NONE;
        end else if (mode == pfb_pkg::MODE_SET) begin
          d_op = pfb_pkg::OP_SET;
        end else begin
          d_op = pfb_pkg::OP_CLEAR;
        end
      end
      default: d_op = pfb_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_up  <= d_page_up;
      page_lo  <= d_page_lo;
      col      <= d_col;
      mask_up  <= d_mask_up;
      mask_lo  <= d_mask_lo;
      op       <= d_op;
      has_lo_q <= d_has_lo;
    end
  end

  assign stat.clear_done = clr_cnt[AW];
  assign stat.has_up     = d_has_up;
  assign stat.has_lo     = d_has_lo;
  assign stat.has_lo_q   = has_lo_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign sel_page = cmd.sel_lo ? page_lo : page_up;
  assign addr     = {sel_page[PGW-1:0], col[CW-1:0]};
  assign new_byte = pfb_pkg::apply_op(rdata, cmd.sel_lo ? mask_lo : mask_up, op);

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      frame_mem[clr_cnt[AW-1:0]] <= '0;
    end else if (cmd.write) begin
      frame_mem[addr] <= new_byte;
    end
    if (cmd.read) begin
      rdata <= frame_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.write;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      page_index   <= sel_page[2:0];
      column_index <= col[6:0];
      byte_value   <= new_byte;
      is_last      <= cmd.last;
    end
  end

endmodule

// File: design/page_framebuffer_blitter.sv
// Channel   Handshake            Ports
// -------   ------------------   ----------------------------------------------------
// item      start && !busy       command origin_x origin_y col_offset band
//                                bitmap_byte mode blit_width blit_height
// result    strobe (one cycle)   page_index column_index byte_value is_last
//
// An item is taken in the idle state. Each frame byte it touches is read and then
// modified and written back through the single frame memory port, and the result
// is registered from the write and appears in the cycle after it; an item that
// touches nothing gives no result and leaves the block idle.
// After reset a clearing pass zeroes the frame memory, one byte a cycle, all
// 2**(clog2(SCREEN_PAGES)+clog2(SCREEN_COLUMNS)) bytes of it (1024 by default), and
// busy falls once the controller has seen it done. The receiver cannot stall: each
// result shows for one cycle only.
module page_framebuffer_blitter #(
  parameter int unsigned SCREEN_COLUMNS = 128,
  parameter int unsigned SCREEN_PAGES   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic signed [7:0] origin_x,
  input  logic signed [7:0] origin_y,
  input  logic [7:0]        col_offset,
  input  logic [4:0]        band,
  input  logic [7:0]        bitmap_byte,
  input  logic [1:0]        mode,
  input  logic [7:0]        blit_width,
  input  logic [7:0]        blit_height,
  output logic              strobe,
  output logic [2:0]        page_index,
  output logic [6:0]        column_index,
  output logic [7:0]        byte_value,
  output logic              is_last
);

  // The controller sequences the clearing pass and the read and write cycles of
  // each item; the datapath decodes the item, holds the frame memory and
  // registers the results.
  pfb_pkg::ctrl_cmd_t  cmd;
  pfb_pkg::ctrl_stat_t stat;

  pfb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pfb_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (command),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .col_offset   (col_offset),
    .band         (band),
    .bitmap_byte  (bitmap_byte),
    .mode         (mode),
    .blit_width   (blit_width),
    .blit_height  (blit_height),
    .strobe       (strobe),
    .page_index   (page_index),
    .column_index (column_index),
    .byte_value   (byte_value),
    .is_last      (is_last)
  );

endmodule
